>>> rtl/core/pucm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pucm_pkg
// Types, register codes and constants shared by the pipe unwrap coordinate map.
// ----------------------------------------------------------------------------
package pucm_pkg;

  localparam int REG_IDX_W = 4;
  localparam int CFG_W     = 64;

  localparam logic [REG_IDX_W-1:0] REG_ROT_ROW_0    = 4'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROT_ROW_1    = 4'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROT_ROW_2    = 4'd2;
  localparam logic [REG_IDX_W-1:0] REG_FOCAL        = 4'd3;
  localparam logic [REG_IDX_W-1:0] REG_CENTER       = 4'd4;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET       = 4'd5;
  localparam logic [REG_IDX_W-1:0] REG_DEPTH        = 4'd6;
  localparam logic [REG_IDX_W-1:0] REG_RADIUS_PHASE = 4'd7;

  localparam logic [53:0] ROT_ROW_0_RESET = 54'd65536;
  localparam logic [53:0] ROT_ROW_1_RESET = 54'd17179869184;
  localparam logic [53:0] ROT_ROW_2_RESET = 54'd4503599627370496;

  // CORDIC datapath widths: x and y in Q1.30 with headroom, residual angle.
  localparam int CW = 34;
  localparam int ZW = 33;
  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

  // Projection divider.
  localparam int NUM_W = 62;
  localparam int DEN_W = 48;

  localparam logic signed [49:0] NEAR_LIMIT    = 50'sd6554;
  localparam logic signed [23:0] INVALID_COORD = -24'sd256;

  typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

  typedef struct packed {
    logic [11:0] column;
    logic [11:0] row;
  } in_req_t;

  typedef struct packed {
    logic signed [23:0] source_x;
    logic signed [23:0] source_y;
    logic               in_front;
  } out_req_t;

  typedef struct packed {
    quad_t              quad;
    logic [11:0]        row;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem_x;
    logic [DEN_W-1:0] rem_y;
    logic [NUM_W-1:0] nq_x;
    logic [NUM_W-1:0] nq_y;
    logic [DEN_W-1:0] den;
    logic             neg_x;
    logic             neg_y;
    logic             front;
    logic [23:0]      cx;
    logic [23:0]      cy;
  } div_t;

  // Arctangent of 2^-i in 2^-32 turns.
  function automatic logic [29:0] atan_turns(input int idx);
    logic [29:0] v;
    case (idx[4:0])
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/pipe_unwrap_coordinate_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipe_unwrap_coordinate_map
// Maps an unwrapped pipe pixel (column, row) to a source image coordinate.
// ----------------------------------------------------------------------------
// One request on in_* carries a column and a row; one request on out_* returns
// source_x and source_y in signed Q16.8 and the in_front flag. Points closer
// than the near limit return -1.0 for both coordinates with in_front low.
// The datapath is a fixed pipeline: input stage, a row of CORDIC_STEPS CORDIC
// cells, seven arithmetic stages (quadrant, wall point, matrix products, sums,
// offset, saturation, numerators), a row of 62 divider cells, sign fix and the
// output register; every stage and cell is registered. One request is accepted
// every cycle while in_stall is low. When out_stall holds a waiting result, the
// whole pipeline freezes and in_stall rises in the same cycle; nothing is
// dropped or repeated. Reset clears all stage valid bits and loads the register
// defaults (identity matrix, all else zero). The cfg_* port writes one register
// per cycle and ignores unknown indexes. The user must use it only while the
// pipeline is empty; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module pipe_unwrap_coordinate_map
  import pucm_pkg::*;
#(
  parameter int MAX_COLUMNS  = 4096,
  parameter int MAX_ROWS     = 4096,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_req_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_req_t             out_data,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int unsigned COL_LIM = MAX_COLUMNS - 1;
  localparam int unsigned ROW_LIM = MAX_ROWS - 1;
  localparam int DIV_STEPS = NUM_W;

  localparam logic signed [66:0] RND30 = 67'sd536870912;
  localparam logic signed [65:0] RND16 = 66'sd32768;
  localparam logic signed [49:0] CAM_MAX = 50'sd137438953471;
  localparam logic signed [49:0] CAM_MIN = -50'sd137438953472;
  localparam logic signed [37:0] S38_MAX = {1'b0, {37{1'b1}}};
  localparam logic signed [37:0] S38_MIN = {1'b1, 37'd0};
  localparam logic signed [61:0] OUT_MAX = 62'sd8388607;
  localparam logic signed [61:0] OUT_MIN = -62'sd8388608;

  // Configuration registers.
  logic [53:0] rot_r [3];
  logic [47:0] focal_r;
  logic [47:0] center_r;
  logic [47:0] offset_r;
  logic [63:0] depth_r;
  logic [63:0] radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r[0] <= ROT_ROW_0_RESET;
      rot_r[1] <= ROT_ROW_1_RESET;
      rot_r[2] <= ROT_ROW_2_RESET;
      focal_r  <= '0;
      center_r <= '0;
      offset_r <= '0;
      depth_r  <= '0;
      radius_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROT_ROW_0:    rot_r[0] <= cfg_data[53:0];
        REG_ROT_ROW_1:    rot_r[1] <= cfg_data[53:0];
        REG_ROT_ROW_2:    rot_r[2] <= cfg_data[53:0];
        REG_FOCAL:        focal_r  <= cfg_data[47:0];
        REG_CENTER:       center_r <= cfg_data[47:0];
        REG_OFFSET:       offset_r <= cfg_data[47:0];
        REG_DEPTH:        depth_r  <= cfg_data;
        REG_RADIUS_PHASE: radius_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [17:0] mat_e [3][3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int j = 0; j < 3; j++) begin
        mat_e[r][j] = $signed(rot_r[r][18*j +: 18]);
      end
    end
  end

  logic signed [31:0] dstart;
  logic signed [31:0] dstep;
  logic        [31:0] radius;
  logic        [31:0] phase_step;
  logic signed [23:0] off_x;
  logic signed [23:0] off_y;

  assign dstart     = $signed(depth_r[31:0]);
  assign dstep      = $signed(depth_r[63:32]);
  assign radius     = radius_r[31:0];
  assign phase_step = radius_r[63:32];
  assign off_x      = $signed(offset_r[23:0]);
  assign off_y      = $signed(offset_r[47:24]);

  // The whole pipeline moves unless a finished result is held by the receiver.
  logic adv;
  logic out_valid_r;
  out_req_t out_data_r;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // Input stage: clamp indices and form the angle.
  logic        s0_valid_r;
  logic [31:0] s0_angle_r;
  logic [11:0] s0_row_r;
  logic [11:0] col_c;
  logic [11:0] row_c;
  logic [43:0] ang_prod;

  assign col_c    = (32'(in_data.column) > COL_LIM) ? 12'(COL_LIM) : in_data.column;
  assign row_c    = (32'(in_data.row) > ROW_LIM) ? 12'(ROW_LIM) : in_data.row;
  assign ang_prod = col_c * phase_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (adv) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_angle_r <= ang_prod[31:0];
      s0_row_r   <= row_c;
    end
  end

  // CORDIC cell row.
  logic    cor_v [CORDIC_STEPS+1];
  cordic_t cor_d [CORDIC_STEPS+1];

  always_comb begin
    cor_v[0]      = s0_valid_r;
    cor_d[0].quad = quad_t'(s0_angle_r[31:30]);
    cor_d[0].row  = s0_row_r;
    cor_d[0].x    = GAIN_Q30;
    cor_d[0].y    = '0;
    cor_d[0].z    = $signed({3'b000, s0_angle_r[29:0]});
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    pucm_cordic_cell #(.STEP(i)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .valid_i (cor_v[i]),
      .data_i  (cor_d[i]),
      .valid_o (cor_v[i+1]),
      .data_o  (cor_d[i+1])
    );
  end

  // Quadrant correction.
  logic                 sq_valid_r;
  logic signed [CW-1:0] sq_c_r;
  logic signed [CW-1:0] sq_s_r;
  logic [11:0]          sq_row_r;
  logic signed [CW-1:0] c_nxt;
  logic signed [CW-1:0] s_nxt;
  cordic_t              cor_last;

  assign cor_last = cor_d[CORDIC_STEPS];

  always_comb begin
    case (cor_last.quad)
      QUAD_0: begin
        c_nxt = cor_last.x;
        s_nxt = cor_last.y;
      end
      QUAD_1: begin
        c_nxt = -cor_last.y;
        s_nxt = cor_last.x;
      end
      QUAD_2: begin
        c_nxt = -cor_last.x;
        s_nxt = -cor_last.y;
      end
      default: begin
        c_nxt = cor_last.y;
        s_nxt = -cor_last.x;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_valid_r <= 1'b0;
    end else if (adv) begin
      sq_valid_r <= cor_v[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_c_r   <= c_nxt;
      sq_s_r   <= s_nxt;
      sq_row_r <= cor_last.row;
    end
  end

  // Wall point on the cylinder.
  logic               sr_valid_r;
  logic signed [44:0] sr_p_r [3];
  logic signed [32:0] rad_s;
  logic signed [66:0] rpx;
  logic signed [66:0] rpy;
  logic signed [66:0] rpx_rnd;
  logic signed [66:0] rpy_rnd;
  logic signed [36:0] px_w;
  logic signed [36:0] py_w;
  logic signed [44:0] row_s;
  logic signed [44:0] step_s;
  logic signed [44:0] start_s;

  assign rad_s   = $signed({1'b0, radius});
  assign rpx     = rad_s * sq_c_r;
  assign rpy     = rad_s * sq_s_r;
  assign rpx_rnd = rpx + RND30;
  assign rpy_rnd = rpy + RND30;
  assign px_w    = rpx_rnd[66:30];
  assign py_w    = rpy_rnd[66:30];
  assign row_s   = 45'($signed({1'b0, sq_row_r}));
  assign step_s  = 45'(dstep);
  assign start_s = 45'(dstart);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_valid_r <= 1'b0;
    end else if (adv) begin
      sr_valid_r <= sq_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sr_p_r[0] <= 45'(px_w);
      sr_p_r[1] <= 45'(py_w);
      sr_p_r[2] <= start_s + row_s * step_s;
    end
  end

  // Matrix products.
  logic               sm_valid_r;
  logic signed [62:0] sm_prod_r [3][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sm_valid_r <= 1'b0;
    end else if (adv) begin
      sm_valid_r <= sr_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          sm_prod_r[r][j] <= mat_e[r][j] * sr_p_r[j];
        end
      end
    end
  end

  // Row sums with the rounding constant for the Q16.16 result.
  logic               sa_valid_r;
  logic signed [65:0] sa_acc_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_valid_r <= 1'b0;
    end else if (adv) begin
      sa_valid_r <= sm_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        sa_acc_r[r] <= 66'(sm_prod_r[r][0]) + 66'(sm_prod_r[r][1])
                     + 66'(sm_prod_r[r][2]) + RND16;
      end
    end
  end

  // Camera offset.
  logic               sb_valid_r;
  logic signed [49:0] sb_camx_r;
  logic signed [49:0] sb_camy_r;
  logic signed [49:0] sb_camz_r;
  logic signed [49:0] camx_w;
  logic signed [49:0] camy_w;
  logic signed [49:0] camz_w;
  logic signed [49:0] offx_w;
  logic signed [49:0] offy_w;

  assign camx_w = sa_acc_r[0][65:16];
  assign camy_w = sa_acc_r[1][65:16];
  assign camz_w = sa_acc_r[2][65:16];
  assign offx_w = 50'($signed({off_x, 4'b0000}));
  assign offy_w = 50'($signed({off_y, 4'b0000}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_valid_r <= 1'b0;
    end else if (adv) begin
      sb_valid_r <= sa_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_camx_r <= camx_w + offx_w;
      sb_camy_r <= camy_w + offy_w;
      sb_camz_r <= camz_w;
    end
  end

  // Saturation to 38 bits, sign and magnitude, near test.
  logic               sc_valid_r;
  logic [37:0]        sc_magx_r;
  logic [37:0]        sc_magy_r;
  logic               sc_negx_r;
  logic               sc_negy_r;
  logic               sc_front_r;
  logic [DEN_W-1:0]   sc_den_r;
  logic signed [37:0] satx;
  logic signed [37:0] saty;

  always_comb begin
    if (sb_camx_r > CAM_MAX) begin
      satx = S38_MAX;
    end else if (sb_camx_r < CAM_MIN) begin
      satx = S38_MIN;
    end else begin
      satx = sb_camx_r[37:0];
    end
    if (sb_camy_r > CAM_MAX) begin
      saty = S38_MAX;
    end else if (sb_camy_r < CAM_MIN) begin
      saty = S38_MIN;
    end else begin
      saty = sb_camy_r[37:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_valid_r <= 1'b0;
    end else if (adv) begin
      sc_valid_r <= sb_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sc_magx_r  <= satx[37] ? 38'(-satx) : satx;
      sc_magy_r  <= saty[37] ? 38'(-saty) : saty;
      sc_negx_r  <= satx[37];
      sc_negy_r  <= saty[37];
      sc_front_r <= sb_camz_r >= NEAR_LIMIT;
      sc_den_r   <= sb_camz_r[DEN_W-1:0];
    end
  end

  // Numerators; their register feeds the divider row.
  logic div_v [DIV_STEPS+1];
  div_t div_d [DIV_STEPS+1];
  logic sn_valid_r;
  div_t sn_data_r;
  div_t sn_data_nxt;
  logic [NUM_W-1:0] numx;
  logic [NUM_W-1:0] numy;

  assign numx = sc_magx_r * focal_r[23:0];
  assign numy = sc_magy_r * focal_r[47:24];

  always_comb begin
    sn_data_nxt.rem_x = '0;
    sn_data_nxt.rem_y = '0;
    sn_data_nxt.nq_x  = numx;
    sn_data_nxt.nq_y  = numy;
    sn_data_nxt.den   = sc_den_r;
    sn_data_nxt.neg_x = sc_negx_r;
    sn_data_nxt.neg_y = sc_negy_r;
    sn_data_nxt.front = sc_front_r;
    sn_data_nxt.cx    = center_r[23:0];
    sn_data_nxt.cy    = center_r[47:24];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sn_valid_r <= 1'b0;
    end else if (adv) begin
      sn_valid_r <= sc_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sn_data_r <= sn_data_nxt;
    end
  end

  assign div_v[0] = sn_valid_r;
  assign div_d[0] = sn_data_r;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    pucm_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .valid_i (div_v[k]),
      .data_i  (div_d[k]),
      .valid_o (div_v[k+1]),
      .data_o  (div_d[k+1])
    );
  end

  // Quotient sign: the divisor is positive, so truncation follows the numerator.
  logic               f1_valid_r;
  logic signed [62:0] f1_qx_r;
  logic signed [62:0] f1_qy_r;
  logic               f1_front_r;
  logic [23:0]        f1_cx_r;
  logic [23:0]        f1_cy_r;
  logic signed [62:0] qx_w;
  logic signed [62:0] qy_w;
  div_t               div_last;

  assign div_last = div_d[DIV_STEPS];
  assign qx_w     = $signed({1'b0, div_last.nq_x});
  assign qy_w     = $signed({1'b0, div_last.nq_y});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else if (adv) begin
      f1_valid_r <= div_v[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_qx_r    <= div_last.neg_x ? -qx_w : qx_w;
      f1_qy_r    <= div_last.neg_y ? -qy_w : qy_w;
      f1_front_r <= div_last.front;
      f1_cx_r    <= div_last.cx;
      f1_cy_r    <= div_last.cy;
    end
  end

  // Add the principal point, round Q.10 to Q.8 and saturate.
  function automatic logic signed [23:0] sat24(input logic signed [61:0] v);
    logic signed [23:0] res;
    if (v > OUT_MAX) begin
      res = OUT_MAX[23:0];
    end else if (v < OUT_MIN) begin
      res = OUT_MIN[23:0];
    end else begin
      res = v[23:0];
    end
    return res;
  endfunction

  logic signed [63:0] tx;
  logic signed [63:0] ty;
  logic signed [61:0] rx;
  logic signed [61:0] ry;
  out_req_t           out_nxt;

  assign tx = 64'(f1_qx_r) + 64'($signed({1'b0, f1_cx_r})) + 64'sd2;
  assign ty = 64'(f1_qy_r) + 64'($signed({1'b0, f1_cy_r})) + 64'sd2;
  assign rx = tx[63:2];
  assign ry = ty[63:2];

  always_comb begin
    if (f1_front_r) begin
      out_nxt.source_x = sat24(rx);
      out_nxt.source_y = sat24(ry);
      out_nxt.in_front = 1'b1;
    end else begin
      out_nxt.source_x = INVALID_COORD;
      out_nxt.source_y = INVALID_COORD;
      out_nxt.in_front = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= f1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/core/pucm_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pucm_cordic_cell
// One rotation-mode CORDIC step, registered, handing its vector to the next.
// ----------------------------------------------------------------------------
module pucm_cordic_cell
  import pucm_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    adv,
  input  logic    valid_i,
  input  cordic_t data_i,
  output logic    valid_o,
  output cordic_t data_o
);

  logic    valid_r;
  cordic_t data_r;
  cordic_t data_nxt;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [ZW-1:0] ang;

  assign dx  = data_i.y >>> STEP;
  assign dy  = data_i.x >>> STEP;
  assign ang = $signed({3'b000, atan_turns(STEP)});

  always_comb begin
    data_nxt = data_i;
    if (!data_i.z[ZW-1]) begin
      data_nxt.x = data_i.x - dx;
      data_nxt.y = data_i.y + dy;
      data_nxt.z = data_i.z - ang;
    end else begin
      data_nxt.x = data_i.x + dx;
      data_nxt.y = data_i.y - dy;
      data_nxt.z = data_i.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

>>> rtl/core/pucm_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pucm_div_cell
// One restoring division step for both projection lanes, registered.
// ----------------------------------------------------------------------------
module pucm_div_cell
  import pucm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  logic valid_i,
  input  div_t data_i,
  output logic valid_o,
  output div_t data_o
);

  logic valid_r;
  div_t data_r;
  div_t data_nxt;
  logic [DEN_W:0] trial_x;
  logic [DEN_W:0] trial_y;
  logic [DEN_W:0] den_w;
  logic           ge_x;
  logic           ge_y;

  // The numerator shifts out at the top while quotient bits enter at the bottom.
  assign trial_x = {data_i.rem_x, data_i.nq_x[NUM_W-1]};
  assign trial_y = {data_i.rem_y, data_i.nq_y[NUM_W-1]};
  assign den_w   = {1'b0, data_i.den};
  assign ge_x    = trial_x >= den_w;
  assign ge_y    = trial_y >= den_w;

  always_comb begin
    data_nxt       = data_i;
    data_nxt.rem_x = ge_x ? DEN_W'(trial_x - den_w) : trial_x[DEN_W-1:0];
    data_nxt.rem_y = ge_y ? DEN_W'(trial_y - den_w) : trial_y[DEN_W-1:0];
    data_nxt.nq_x  = {data_i.nq_x[NUM_W-2:0], ge_x};
    data_nxt.nq_y  = {data_i.nq_y[NUM_W-2:0], ge_y};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

>>> tb/pipe_unwrap_coordinate_map_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipe_unwrap_coordinate_map_tb
// Self-checking bench for the pipe unwrap coordinate map. A local fixed-point
// mapping function predicts every source coordinate from a mirror of the
// registers; results are compared in order under random idling and stalls.
// ----------------------------------------------------------------------------
module pipe_unwrap_coordinate_map_tb;
  import pucm_pkg::*;

  localparam int MAX_COLUMNS  = 4096;
  localparam int MAX_ROWS     = 4096;
  localparam int CORDIC_STEPS = 16;
  localparam int TAIL_CYCLES  = 120;
  localparam int WATCHDOG_MAX = 5000;
  localparam int HOLD_CYCLES  = 400;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 4'd12;

  localparam longint ATAN_TURNS [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0};

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_req_t              in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_req_t             out_data;
  logic                 cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  logic [63:0] reg_mirror [8];
  out_req_t    coord_queue [$];
  int          mismatches = 0;
  int          sent_pixels = 0;
  int          checked_coords = 0;
  int          front_coords = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_left = 0;
  bit          hold_request = 1'b0;
  int          quiet_cycles = 0;

  pipe_unwrap_coordinate_map #(
    .MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS), .CORDIC_STEPS(CORDIC_STEPS)
  ) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, int bits);
    longint hi;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint project_axis(longint v, longint z, longint f, longint cn);
    longint q;
    q = (clip(v, 38) * f) / z;
    return clip(round_shift(q + cn, 2), 24);
  endfunction

  // Expected source coordinate for one output pixel under the mirrored registers.
  function automatic out_req_t map_pixel(logic [11:0] col_in, logic [11:0] row_in);
    longint col, row, x, y, z, dx, dy, c, s, radius, e, acc;
    longint p [3];
    longint cam [3];
    logic [31:0] angle;
    out_req_t r;
    col = col_in;
    row = row_in;
    if (col > MAX_COLUMNS - 1) col = MAX_COLUMNS - 1;
    if (row > MAX_ROWS - 1) row = MAX_ROWS - 1;
    angle = 32'(col * longint'(reg_mirror[REG_RADIUS_PHASE][63:32]));
    x = GAIN_Q30;
    y = 0;
    z = longint'(angle[29:0]);
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TURNS[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TURNS[i];
      end
    end
    case (quad_t'(angle[31:30]))
      QUAD_0: begin c = x;  s = y;  end
      QUAD_1: begin c = -y; s = x;  end
      QUAD_2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    radius = longint'(reg_mirror[REG_RADIUS_PHASE][31:0]);
    p[0] = round_shift(radius * c, 30);
    p[1] = round_shift(radius * s, 30);
    p[2] = longint'($signed(reg_mirror[REG_DEPTH][31:0]))
         + row * longint'($signed(reg_mirror[REG_DEPTH][63:32]));
    for (int k = 0; k < 3; k++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) begin
        e = longint'($signed(reg_mirror[k][18*j +: 18]));
        acc += e * p[j];
      end
      cam[k] = round_shift(acc, 16);
    end
    cam[0] += longint'($signed(reg_mirror[REG_OFFSET][23:0])) * 16;
    cam[1] += longint'($signed(reg_mirror[REG_OFFSET][47:24])) * 16;
    if (cam[2] < longint'(NEAR_LIMIT)) begin
      r.source_x = INVALID_COORD;
      r.source_y = INVALID_COORD;
      r.in_front = 1'b0;
    end else begin
      r.source_x = 24'(project_axis(cam[0], cam[2],
        longint'(reg_mirror[REG_FOCAL][23:0]), longint'(reg_mirror[REG_CENTER][23:0])));
      r.source_y = 24'(project_axis(cam[1], cam[2],
        longint'(reg_mirror[REG_FOCAL][47:24]), longint'(reg_mirror[REG_CENTER][47:24])));
      r.in_front = 1'b1;
    end
    return r;
  endfunction

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [63:0] value);
    int w;
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx <= REG_RADIUS_PHASE) begin
      w = (idx <= REG_ROT_ROW_2) ? 54 : (idx <= REG_OFFSET) ? 48 : 64;
      reg_mirror[idx] = (w == 64) ? value : (value & ((64'd1 << w) - 1));
    end
  endtask

  task automatic send_pixel(logic [11:0] col, logic [11:0] row);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 200) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{column: col, row: row};
    do @(posedge clk); while (in_stall);
    coord_queue.push_back(map_pixel(col, row));
    sent_pixels++;
  endtask

  // Lets the pipeline empty before the registers change.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (coord_queue.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic load_setup(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
                            logic [63:0] f, logic [63:0] cn, logic [63:0] off,
                            logic [63:0] d, logic [63:0] rp);
    write_reg(REG_ROT_ROW_0, r0);
    write_reg(REG_ROT_ROW_1, r1);
    write_reg(REG_ROT_ROW_2, r2);
    write_reg(REG_FOCAL, f);
    write_reg(REG_CENTER, cn);
    write_reg(REG_OFFSET, off);
    write_reg(REG_DEPTH, d);
    write_reg(REG_RADIUS_PHASE, rp);
  endtask

  function automatic logic [17:0] near_unit_entry(bit diag);
    int v;
    v = diag ? $urandom_range(80000) - 8000 : $urandom_range(40000) - 20000;
    return 18'(v);
  endfunction

  task automatic randomize_setup(bit wild);
    logic [63:0] rows [3];
    if (wild) begin
      load_setup({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom});
    end else begin
      for (int k = 0; k < 3; k++) begin
        rows[k] = 64'({near_unit_entry(k == 2), near_unit_entry(k == 1),
                       near_unit_entry(k == 0)});
      end
      load_setup(rows[0], rows[1], rows[2],
                 {16'd0, 24'($urandom_range(4000 << 10)), 24'($urandom_range(4000 << 10))},
                 {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF,
                 {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF,
                 {32'($urandom_range(4000) - 2000), 32'($urandom_range(60 << 16))},
                 {$urandom, 32'($urandom_range(200 << 16))});
    end
  endtask

  task automatic test_reset_defaults;
    // Zero depth after reset puts every point short of the near limit.
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'h555, 12'hAAA);
    drain();
  endtask

  task automatic test_directed;
    // Identity matrix, 500 px focal, center (320, 240), depth 1.0 + 0.01 per row.
    load_setup(64'(ROT_ROW_0_RESET), 64'(ROT_ROW_1_RESET), 64'(ROT_ROW_2_RESET),
               64'({24'd512000, 24'd512000}), 64'({24'd245760, 24'd327680}), 64'd0,
               {32'd655, 32'd65536}, {32'd1048576, 32'd32768});
    write_reg(REG_UNUSED, {64{1'b1}});
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1024, 12'd10);
    send_pixel(12'd2048, 12'd100);
    send_pixel(12'd3072, 12'd1000);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'd0, 12'hFFF);
    send_pixel(12'hFFF, 12'd0);
    drain();
    // Depth just below, at and just above the near limit.
    write_reg(REG_DEPTH, {32'd1, 32'd6553});
    send_pixel(12'd7, 12'd0);
    send_pixel(12'd7, 12'd1);
    send_pixel(12'd7, 12'd2);
    drain();
    // Behind the camera.
    write_reg(REG_DEPTH, {32'hFFFF_0000, 32'hFFF0_0000});
    send_pixel(12'd100, 12'd0);
    send_pixel(12'd100, 12'hFFF);
    drain();
    // Huge radius and focal at minimum depth drive both coordinates to saturation.
    load_setup(64'(ROT_ROW_0_RESET), 64'(ROT_ROW_1_RESET), 64'(ROT_ROW_2_RESET),
               64'({48{1'b1}}), 64'({48{1'b1}}), 64'({24'h7FFFFF, 24'h800000}),
               {32'd0, 32'd6554}, {32'd1 << 30, 32'hFFFF_FFFF});
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd5);
    send_pixel(12'd2, 12'hFFF);
    send_pixel(12'hFFF, 12'd3);
    drain();
    // Every register at all ones, then all zeros.
    load_setup({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}},
               {64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}});
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'd0, 12'd0);
    drain();
    load_setup(64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0);
    send_pixel(12'h800, 12'h800);
    drain();
  endtask

  task automatic test_random_phase(int s_pct, int r_pct, int count);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int n = 0; n < count; n++) begin
      if (n % 80 == 0) begin
        drain();
        randomize_setup(n % 240 == 160);
      end
      // Mostly raster runs along a row, as a video scan would produce.
      if ($urandom_range(3) != 0)
        send_pixel(12'(n % 80 + (n / 80) * 97), 12'((n / 80) * 311 + 5));
      else
        send_pixel(12'($urandom), 12'($urandom));
    end
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
  endtask

  task automatic test_backpressure;
    randomize_setup(1'b0);
    hold_request = 1'b1;
    for (int n = 0; n < 150; n++) send_pixel(12'($urandom), 12'($urandom));
    drain();
  endtask

  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    out_req_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (coord_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result x=%0d y=%0d f=%0b",
                   out_data.source_x, out_data.source_y, out_data.in_front);
      end else begin
        want = coord_queue.pop_front();
        checked_coords++;
        if (want.in_front) front_coords++;
        if (out_data.source_x !== want.source_x || out_data.source_y !== want.source_y ||
            out_data.in_front !== want.in_front) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x=%0d y=%0d f=%0b, got x=%0d y=%0d f=%0b",
                     want.source_x, want.source_y, want.in_front,
                     out_data.source_x, out_data.source_y, out_data.in_front);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("timeout with %0d results outstanding", coord_queue.size());
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    reg_mirror[REG_ROT_ROW_0]    = 64'(ROT_ROW_0_RESET);
    reg_mirror[REG_ROT_ROW_1]    = 64'(ROT_ROW_1_RESET);
    reg_mirror[REG_ROT_ROW_2]    = 64'(ROT_ROW_2_RESET);
    for (int k = 3; k < 8; k++) reg_mirror[k] = 64'd0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_random_phase(0, 0, 300);
    test_random_phase(78, 0, 300);
    test_random_phase(0, 78, 300);
    test_random_phase(30, 30, 300);
    test_backpressure();
    $display("Sent %0d pixels, checked %0d coordinates (%0d in front of the camera).",
             sent_pixels, checked_coords, front_coords);
    $display("Covered near-limit, behind-camera, saturation, register extremes and stalls.");
    if (mismatches == 0 && coord_queue.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, coord_queue.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/pucm_pkg.sv
rtl/core/pucm_cordic_cell.sv
rtl/core/pucm_div_cell.sv
rtl/core/pipe_unwrap_coordinate_map.sv
tb/pipe_unwrap_coordinate_map_tb.sv
